@@ design/sktrs_pkg.sv @@
// Shared types, constants and helpers for the sorted key table with rotating select.
// Depends on nothing; every other design file imports it.
package sktrs_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int ITER_W      = 32;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STEPS   = ITER_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		FN_INSERT   = 2'd0,
		FN_REMOVE   = 2'd1,
		FN_DISPATCH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		RS_INSERTED   = 3'd0,
		RS_REPLACED   = 3'd1,
		RS_REMOVED    = 3'd2,
		RS_NOT_FOUND  = 3'd3,
		RS_FULL       = 3'd4,
		RS_DISPATCHED = 3'd5,
		RS_NONE_READY = 3'd6,
		RS_EMPTY      = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY,
		ST_DIV,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] key;
		logic [31:0] handler_tag;
		logic [15:0] ready_mask;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [15:0] chosen_key;
		logic [31:0] chosen_tag;
		logic [4:0]  entry_count;
	} rsp_t;

	// Per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic rem;
		logic rep;
	} cell_cmd_t;

	function automatic logic [3:0] to_slot(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[3:0];
	endfunction

	function automatic logic [4:0] to_count(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[4:0];
	endfunction

endpackage

@@ design/sktrs_cell.sv @@
// One slot of the sorted table: key and tag registers, key compare, shift mux.
// Depends on sktrs_pkg.
module sktrs_cell (
	input  logic                  clk,
	input  sktrs_pkg::cell_cmd_t  cmd,
	input  logic                  in_use,
	input  logic [15:0]           new_key,
	input  logic [31:0]           new_tag,
	input  logic                  left_lt,
	input  logic [15:0]           left_key,
	input  logic [31:0]           left_tag,
	input  logic [15:0]           right_key,
	input  logic [31:0]           right_tag,
	output logic [15:0]           key,
	output logic [31:0]           tag,
	output logic                  lt,
	output logic                  eq
);
	import sktrs_pkg::*;

	logic [15:0] key_q;
	logic [31:0] tag_q;
	logic        lt_q;
	logic        eq_q;

	always_ff @(posedge clk) begin
		lt_q <= in_use && (key_q < new_key);
		eq_q <= in_use && (key_q == new_key);
		if (cmd.ins && !lt_q) begin
			// the first cell at or above the insert point takes the new item
			if (left_lt) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end else begin
				key_q <= left_key;
				tag_q <= left_tag;
			end
		end else if (cmd.rem && !lt_q) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (cmd.rep && eq_q) begin
			tag_q <= new_tag;
		end
	end

	assign key = key_q;
	assign tag = tag_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

@@ design/sktrs_mod.sv @@
// Iterative remainder unit: dividend modulo a nonzero count, DIV_BITS bits per cycle.
// Depends on sktrs_pkg.
module sktrs_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sktrs_pkg::ITER_W-1:0] dividend,
	input  logic [sktrs_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [sktrs_pkg::CNT_W-1:0]  rem
);
	import sktrs_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [ITER_W-1:0]    num_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     rem_d;
	logic [CNT_W:0]       trial;

	// DIV_BITS restoring steps on narrow values
	always_comb begin
		rem_d = rem_q;
		trial = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial = {rem_d, num_q[ITER_W-1-b]};
			if (trial >= {1'b0, div_q})
				trial = trial - {1'b0, div_q};
			rem_d = trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << DIV_BITS;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ design/sorted_key_table_rotating_select.sv @@
// Top level of the sorted key table with rotating select: control, cell row, result register.
// Depends on sktrs_pkg, sktrs_cell and sktrs_mod.
//
// Item sequence: an insert or remove goes through capture, parallel compare in every cell
// and shift of the cell row before the done strobe. A dispatch on an empty table answers
// straight from the idle state; otherwise its result waits on the remainder unit that forms
// the start slot from the 32-bit iteration counter modulo the entry count, 4 bits per
// cycle. An item with function code 3 is taken and gives no result. busy is
// high while an item is in work; done marks the single cycle in which rsp is valid and
// the receiver must take it then. The table needs no clearing after reset.
module sorted_key_table_rotating_select (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sktrs_pkg::req_t req,
	output logic            done,
	output sktrs_pkg::rsp_t rsp
);
	import sktrs_pkg::*;

	state_t            state_q, state_d;
	req_t              req_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              done_q, emit;
	rsp_t              rsp_q, rsp_d;
	cell_cmd_t         cmd;
	logic              div_start, div_done;
	logic [CNT_W-1:0]  div_rem;

	logic [15:0] key_w [TABLE_SLOTS];
	logic [31:0] tag_w [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] lt_w, eq_w, use_w;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
			localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
			logic        l_lt;
			logic [15:0] l_key, r_key;
			logic [31:0] l_tag, r_tag;
			assign use_w[gi] = IDX < count_q;
			if (gi == 0) begin : g_first
				assign l_lt  = 1'b1;
				assign l_key = key_w[gi];
				assign l_tag = tag_w[gi];
			end else begin : g_mid
				assign l_lt  = lt_w[gi-1];
				assign l_key = key_w[gi-1];
				assign l_tag = tag_w[gi-1];
			end
			if (gi == TABLE_SLOTS - 1) begin : g_last
				assign r_key = key_w[gi];
				assign r_tag = tag_w[gi];
			end else begin : g_inner
				assign r_key = key_w[gi+1];
				assign r_tag = tag_w[gi+1];
			end
			sktrs_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.in_use    (use_w[gi]),
				.new_key   (req_q.key),
				.new_tag   (req_q.handler_tag),
				.left_lt   (l_lt),
				.left_key  (l_key),
				.left_tag  (l_tag),
				.right_key (r_key),
				.right_tag (r_tag),
				.key       (key_w[gi]),
				.tag       (tag_w[gi]),
				.lt        (lt_w[gi]),
				.eq        (eq_w[gi])
			);
		end
	endgenerate

	sktrs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (iter_q),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Lower bound: first cell whose key is not below the item key
	logic [CNT_W-1:0] at;
	logic             found;
	always_comb begin
		at = CNT_W'(TABLE_SLOTS);
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!lt_w[i])
				at = CNT_W'(i);
		end
		found = |eq_w;
	end

	// Ring scan from the remainder: first ready slot at or after it, else first overall
	logic [TABLE_SLOTS+15:0] rdy_wide;
	logic [TABLE_SLOTS-1:0]  rdy, rdy_hi;
	logic [SLOT_W-1:0]       sel, sel_hi, sel_lo;
	logic                    any_hi, any_lo;
	always_comb begin
		rdy_wide = {{TABLE_SLOTS{1'b0}}, req_q.ready_mask};
		sel_hi   = '0;
		sel_lo   = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			rdy[i]    = rdy_wide[i] && use_w[i];
			rdy_hi[i] = rdy[i] && (CNT_W'(i) >= div_rem);
		end
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (rdy_hi[i])
				sel_hi = SLOT_W'(i);
			if (rdy[i])
				sel_lo = SLOT_W'(i);
		end
		any_hi = |rdy_hi;
		any_lo = |rdy;
		sel    = any_hi ? sel_hi : sel_lo;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		iter_d    = iter_q;
		cmd       = '0;
		emit      = 1'b0;
		rsp_d     = '0;
		rsp_d.entry_count = to_count(count_q);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.func)
						FN_INSERT, FN_REMOVE: state_d = ST_CMP;
						FN_DISPATCH: begin
							iter_d = iter_q + 1'b1;
							if (count_q == '0) begin
								emit         = 1'b1;
								rsp_d.status = RS_EMPTY;
							end else begin
								state_d = ST_DIV;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CMP: state_d = ST_APPLY;
			ST_APPLY: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (req_q.func == FN_INSERT) begin
					if (found) begin
						cmd.rep      = 1'b1;
						rsp_d.status = RS_REPLACED;
						rsp_d.slot   = to_slot(at);
					end else if (count_q == CNT_W'(TABLE_SLOTS)) begin
						rsp_d.status = RS_FULL;
					end else begin
						cmd.ins      = 1'b1;
						count_d      = count_q + 1'b1;
						rsp_d.status = RS_INSERTED;
						rsp_d.slot   = to_slot(at);
					end
				end else begin
					if (found) begin
						cmd.rem      = 1'b1;
						count_d      = count_q - 1'b1;
						rsp_d.status = RS_REMOVED;
						rsp_d.slot   = to_slot(at);
					end else begin
						rsp_d.status = RS_NOT_FOUND;
					end
				end
				rsp_d.entry_count = to_count(count_d);
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (any_lo) begin
					rsp_d.status     = RS_DISPATCHED;
					rsp_d.slot       = to_slot(CNT_W'(sel));
					rsp_d.chosen_key = key_w[sel];
					rsp_d.chosen_tag = tag_w[sel];
				end else begin
					rsp_d.status = RS_NONE_READY;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Kick the remainder unit in the cycle after capture, once iter_q holds the new value
	logic div_kick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			iter_q     <= '0;
			done_q     <= 1'b0;
			div_kick_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			iter_q     <= iter_d;
			done_q     <= emit;
			div_kick_q <= (state_q == ST_IDLE) && (state_d == ST_DIV);
		end
	end

	assign div_start = div_kick_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			req_q <= req;
		if (emit)
			rsp_q <= rsp_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_SLOTS))
		else $error("entry count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			(count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
		else $error("entry count moved by more than one");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("remainder finished outside dispatch");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (div_rem < count_q))
		else $error("ring start beyond entry count");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_APPLY || $past(state_q) == ST_SCAN
			|| $past(state_q) == ST_IDLE))
		else $error("result strobe from a working state");

endmodule
